[rtl/wildcard_byte_pattern_scanner_assert.svh]
// Assertion macros shared by the wildcard byte pattern scanner RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WBPS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wbps assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wbps assertion failed");

`endif

[rtl/wbps_pkg.sv]
// Package with constants, types and register codes of the byte pattern scanner.
package wbps_pkg;

   // Longest signature in bytes and width of the region position counter.
   localparam int MAX_PATTERN  = 32;
   localparam int OFFSET_WIDTH = 32;

   // Width of the pattern length register and of the reported offset.
   localparam int LEN_WIDTH    = $clog2(MAX_PATTERN + 1);
   localparam int CFG_LEN_BITS = 6;
   localparam int RESULT_WIDTH = 32;

   // Configuration port geometry.
   localparam int PATTERN_WORDS = 4;
   localparam int WORD_WIDTH    = 64;
   localparam int CSR_IDX_WIDTH = 3;

   // A signature byte with this value matches any data byte.
   localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PATTERN_WORD0  = 3'd0,
      CSR_PATTERN_WORD1  = 3'd1,
      CSR_PATTERN_WORD2  = 3'd2,
      CSR_PATTERN_WORD3  = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4
   } csr_index_type;

   typedef logic [MAX_PATTERN-1:0][7:0]                window_type;
   typedef logic [PATTERN_WORDS-1:0][WORD_WIDTH-1:0]   pattern_type;

endpackage

[rtl/wildcard_byte_pattern_scanner.sv]
// Top level of the wildcard byte pattern scanner.
//
// Scans a region streamed one byte per request for a signature of 1 to 32 bytes,
// where a signature byte of 0x2A matches any byte. On the request flagged
// region_end, one result reports whether a match was found, the start offset of
// the first match and whether another match starts at or after the end of the
// first one; the state is then cleared for the next region. The block takes one
// byte every cycle unless a region-end byte waits on a stalled result; the
// result register is loaded from the single window compare behind the input
// register. The user writes the signature and its length through the csr port
// only while no request is in flight; the block itself does not enforce this.
module wildcard_byte_pattern_scanner (
   input  logic                                   clock,
   input  logic                                   reset,
   // Byte request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_data_byte,
   input  logic                                   req_region_end,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [wbps_pkg::RESULT_WIDTH-1:0]      rsp_match_offset,
   output logic                                   rsp_another_match,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wbps_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [wbps_pkg::WORD_WIDTH-1:0]        csr_wdata
);

   `include "wildcard_byte_pattern_scanner_assert.svh"

   localparam int OW = wbps_pkg::OFFSET_WIDTH;

   // Configuration registers.
   wbps_pkg::pattern_type              pattern_ff, pattern_in;
   logic [wbps_pkg::LEN_WIDTH-1:0]     length_ff, length_in;

   // Input register.
   logic                               in_valid_ff, in_valid_in;
   logic [7:0]                         in_byte_ff, in_byte_in;
   logic                               in_end_ff, in_end_in;

   // Region state.
   wbps_pkg::window_type               window_ff, window_in;
   logic [OW-1:0]                      position_ff, position_in;
   logic                               first_found_ff, first_found_in;
   logic [OW-1:0]                      first_offset_ff, first_offset_in;
   logic                               second_found_ff, second_found_in;

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [wbps_pkg::RESULT_WIDTH-1:0]  rsp_offset_ff, rsp_offset_in;
   logic                               rsp_another_ff, rsp_another_in;

   logic                               req_accept;
   logic                               process;
   logic                               hit;
   logic                               saturated;
   logic [OW:0]                        pos_plus_one;
   logic [OW:0]                        len_ext;
   logic [OW-1:0]                      start;
   logic [OW:0]                        bound;
   logic                               upd_first_found;
   logic [OW-1:0]                      upd_first_offset;
   logic                               upd_second_found;
   logic [wbps_pkg::CFG_LEN_BITS-1:0]  wr_length;

   // Configuration writes: the length is clamped to the legal range on write.
   assign csr_ready = 1'b1;
   assign wr_length = csr_wdata[wbps_pkg::CFG_LEN_BITS-1:0];

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wbps_pkg::CSR_PATTERN_WORD0: pattern_in[0] = csr_wdata;
            wbps_pkg::CSR_PATTERN_WORD1: pattern_in[1] = csr_wdata;
            wbps_pkg::CSR_PATTERN_WORD2: pattern_in[2] = csr_wdata;
            wbps_pkg::CSR_PATTERN_WORD3: pattern_in[3] = csr_wdata;
            wbps_pkg::CSR_PATTERN_LENGTH: begin
               if (wr_length == '0) begin
                  length_in = wbps_pkg::LEN_WIDTH'(1);
               end else if (wbps_pkg::CFG_LEN_BITS'(wbps_pkg::MAX_PATTERN) < wr_length) begin
                  length_in = wbps_pkg::LEN_WIDTH'(wbps_pkg::MAX_PATTERN);
               end else begin
                  length_in = wbps_pkg::LEN_WIDTH'(wr_length);
               end
            end
            default: begin
               pattern_in = pattern_ff;
            end
         endcase
      end
   end

   // Handshake: a held byte moves on unless it closes a region and the result
   // register is still occupied and stalled.
   assign process    = in_valid_ff && !(in_end_ff && rsp_valid_ff && rsp_stall);
   assign req_stall  = in_valid_ff && !process;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_end_in   = req_region_end;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   // Shift the held byte into the window.
   always_comb begin
      window_in    = window_ff;
      window_in[0] = in_byte_ff;
      for (int k = 1; k < wbps_pkg::MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   wbps_match u_match (
      .window  (window_in),
      .pattern (pattern_ff),
      .length  (length_ff),
      .hit     (hit)
   );

   // Match bookkeeping for the held byte.
   assign saturated    = (position_ff == '1);
   assign pos_plus_one = {1'b0, position_ff} + (OW+1)'(1);
   assign len_ext      = (OW+1)'(length_ff);
   assign start        = OW'(pos_plus_one - len_ext);
   assign bound        = {1'b0, first_offset_ff} + len_ext;

   always_comb begin
      upd_first_found  = first_found_ff;
      upd_first_offset = first_offset_ff;
      upd_second_found = second_found_ff;
      if (!saturated && (pos_plus_one >= len_ext) && hit) begin
         if (!first_found_ff) begin
            upd_first_found  = 1'b1;
            upd_first_offset = start;
         end else if ({1'b0, start} >= bound) begin
            upd_second_found = 1'b1;
         end
      end
   end

   // State update; the region end clears the state after reporting.
   always_comb begin
      position_in     = position_ff;
      first_found_in  = first_found_ff;
      first_offset_in = first_offset_ff;
      second_found_in = second_found_ff;
      if (process) begin
         if (in_end_ff) begin
            position_in     = '0;
            first_found_in  = 1'b0;
            first_offset_in = '0;
            second_found_in = 1'b0;
         end else begin
            position_in     = saturated ? position_ff : OW'(pos_plus_one);
            first_found_in  = upd_first_found;
            first_offset_in = upd_first_offset;
            second_found_in = upd_second_found;
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_another_in = rsp_another_ff;
      if (process && in_end_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_found_in   = upd_first_found;
         rsp_offset_in  = upd_first_found ?
                          wbps_pkg::RESULT_WIDTH'(upd_first_offset) : '0;
         rsp_another_in = upd_second_found;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in   = 1'b0;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff      <= '0;
         length_ff       <= wbps_pkg::LEN_WIDTH'(1);
         in_valid_ff     <= 1'b0;
         position_ff     <= '0;
         first_found_ff  <= 1'b0;
         first_offset_ff <= '0;
         second_found_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_ff      <= pattern_in;
         length_ff       <= length_in;
         in_valid_ff     <= in_valid_in;
         position_ff     <= position_in;
         first_found_ff  <= first_found_in;
         first_offset_ff <= first_offset_in;
         second_found_ff <= second_found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers; window bytes older than the region start are never used.
   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      in_end_ff      <= in_end_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_another_ff <= rsp_another_in;
      if (process) begin
         window_ff <= window_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_offset  = rsp_offset_ff;
   assign rsp_another_match = rsp_another_ff;

   // A result without a match carries no offset and no second match.
   `WBPS_ASSERT_SAME(a_no_match_clean, rsp_valid && !rsp_found, (rsp_match_offset == '0) && !rsp_another_match)
   // A second match is only ever recorded after a first one.
   `WBPS_ASSERT_SAME(a_second_after_first, second_found_ff, first_found_ff)
   // The first match starts before the current position.
   `WBPS_ASSERT_SAME(a_offset_behind_pos, first_found_ff, first_offset_ff < position_ff)
   // Closing a region leaves the state cleared.
   `WBPS_ASSERT_NEXT(a_region_cleared, process && in_end_ff, (position_ff == '0) && !first_found_ff && !second_found_ff)

endmodule

[rtl/wbps_match.sv]
// Window compare: checks the newest bytes against the signature with wildcards.
module wbps_match (
   input  wbps_pkg::window_type              window,
   input  wbps_pkg::pattern_type             pattern,
   input  logic [wbps_pkg::LEN_WIDTH-1:0]    length,
   output logic                              hit
);

   localparam int WIN_BITS = 8 * wbps_pkg::MAX_PATTERN;

   logic [WIN_BITS-1:0]                        reversed;
   logic [WIN_BITS-1:0]                        aligned;
   logic [wbps_pkg::LEN_WIDTH-1:0]             shift;
   logic [wbps_pkg::PATTERN_WORDS*wbps_pkg::WORD_WIDTH-1:0] sig_flat;
   logic [wbps_pkg::MAX_PATTERN-1:0]           byte_ok;

   // Reverse the window so that the oldest byte in use lands at byte 0 after
   // a right shift by the number of unused window entries.
   always_comb begin
      for (int m = 0; m < wbps_pkg::MAX_PATTERN; m++) begin
         reversed[8*m +: 8] = window[wbps_pkg::MAX_PATTERN-1-m];
      end
   end

   assign shift    = wbps_pkg::LEN_WIDTH'(wbps_pkg::MAX_PATTERN) - length;
   assign aligned  = reversed >> {shift, 3'b000};
   assign sig_flat = pattern;

   // Each signature byte in use must be a wildcard or equal the aligned byte.
   always_comb begin
      for (int i = 0; i < wbps_pkg::MAX_PATTERN; i++) begin
         byte_ok[i] = (wbps_pkg::LEN_WIDTH'(i) >= length)
                   || (sig_flat[8*i +: 8] == wbps_pkg::WILDCARD_BYTE)
                   || (sig_flat[8*i +: 8] == aligned[8*i +: 8]);
      end
   end

   assign hit = &byte_ok;

endmodule

[tb/tb_wildcard_byte_pattern_scanner.sv]
`timescale 1ns / 1ps
// Self-checking testbench that streams byte regions into the wildcard pattern scanner.
module tb_wildcard_byte_pattern_scanner;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 6;
   localparam longint unsigned POSITION_MAX = (64'd1 << wbps_pkg::OFFSET_WIDTH) - 1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_end;
   } byte_request_type;

   typedef struct packed {
      logic                              found;
      logic [wbps_pkg::RESULT_WIDTH-1:0] match_offset;
      logic                              another_match;
   } region_report_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // Block ports, all inputs known from time zero.
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [7:0]                         req_data_byte = 8'h00;
   logic                               req_region_end = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_found;
   logic [wbps_pkg::RESULT_WIDTH-1:0]  rsp_match_offset;
   logic                               rsp_another_match;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [wbps_pkg::CSR_IDX_WIDTH-1:0] csr_index = wbps_pkg::CSR_PATTERN_WORD0;
   logic [wbps_pkg::WORD_WIDTH-1:0]    csr_wdata = '0;

   wildcard_byte_pattern_scanner dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_region_end    (req_region_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_another_match (rsp_another_match),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Shadow copy of the signature registers.
   wbps_pkg::pattern_type sig_words  = '0;
   logic [wbps_pkg::CFG_LEN_BITS-1:0] sig_length = 1;

   // Shadow copy of the scan state for the current region.
   wbps_pkg::window_type recent_bytes = '0;
   longint unsigned position     = 0;
   bit              first_found  = 1'b0;
   longint unsigned first_offset = 0;
   bit              second_found = 1'b0;

   // Request and report bookkeeping.
   byte_request_type  pending_bytes[$];
   region_report_type expected_reports[$];
   int requests_in_flight = 0;
   int items_queued       = 0;
   int regions_queued     = 0;
   int failures           = 0;
   int idle_cycles        = 0;

   // Flow control knobs set per phase.
   bit quiet_run     = 1'b0;
   int gap_percent   = 0;
   int stall_percent = 0;
   int gap_left      = 0;
   int stall_left    = 0;

   // Signature length actually in force for a given register value.
   function automatic int unsigned span_of(input logic [wbps_pkg::CFG_LEN_BITS-1:0] n);
      if (n == 0) return 1;
      if (n > wbps_pkg::MAX_PATTERN) return wbps_pkg::MAX_PATTERN;
      return n;
   endfunction

   function automatic logic [7:0] sig_byte(input int unsigned i);
      return sig_words[i / 8][(i % 8) * 8 +: 8];
   endfunction

   // Advances the scan state by one byte and queues the region report on its last byte.
   function automatic void scan_byte(input logic [7:0] value, input logic last);
      int unsigned       span;
      longint unsigned   start;
      bit                hit;
      region_report_type report;
      span = span_of(sig_length);
      recent_bytes = {recent_bytes[wbps_pkg::MAX_PATTERN-2:0], value};
      if (position < POSITION_MAX) begin
         if (position + 1 >= span) begin
            hit = 1'b1;
            for (int i = 0; i < span; i++) begin
               if (sig_byte(i) != wbps_pkg::WILDCARD_BYTE &&
                   sig_byte(i) != recent_bytes[span - 1 - i]) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               start = position + 1 - span;
               if (!first_found) begin
                  first_found  = 1'b1;
                  first_offset = start;
               end else if (start >= first_offset + span) begin
                  second_found = 1'b1;
               end
            end
         end
         position++;
      end
      if (last) begin
         report.found         = first_found;
         report.match_offset  = first_found ? wbps_pkg::RESULT_WIDTH'(first_offset) : '0;
         report.another_match = second_found;
         expected_reports = {expected_reports, report};
         recent_bytes = '0;
         position     = 0;
         first_found  = 1'b0;
         first_offset = 0;
         second_found = 1'b0;
      end
   endfunction

   task automatic push_byte(input logic [7:0] value, input logic last);
      byte_request_type item;
      item.data_byte  = value;
      item.region_end = last;
      pending_bytes = {pending_bytes, item};
      requests_in_flight++;
      items_queued++;
      if (last) regions_queued++;
   endtask

   // Builds a region from background bytes with planted, sometimes damaged, signature copies.
   task automatic queue_region(input int unsigned count);
      logic [7:0]  bytes[$];
      int unsigned span;
      int unsigned copies;
      int unsigned at;
      int unsigned style;
      span  = span_of(sig_length);
      style = $urandom_range(2);
      for (int i = 0; i < count; i++) begin
         if (style == 0) begin
            bytes = {bytes, 8'($urandom)};
         end else if (style == 1) begin
            bytes = {bytes, sig_byte($urandom_range(span - 1))};
         end else if ($urandom_range(2) == 0) begin
            bytes = {bytes, 8'($urandom)};
         end else begin
            bytes = {bytes, ($urandom_range(1) != 0) ? 8'h00 : 8'hFF};
         end
      end
      copies = ($urandom_range(4) == 0) ? 0 : $urandom_range(3, 1);
      if (count >= span) begin
         for (int c = 0; c < copies; c++) begin
            at = ($urandom_range(3) == 0) ? count - span : $urandom_range(count - span);
            for (int i = 0; i < span; i++) begin
               bytes[at + i] = (sig_byte(i) == wbps_pkg::WILDCARD_BYTE) ?
                               8'($urandom) : sig_byte(i);
            end
            if ($urandom_range(3) == 0) begin
               bytes[at + $urandom_range(span - 1)] ^= 8'($urandom_range(255, 1));
            end
         end
      end
      foreach (bytes[i]) push_byte(bytes[i], i == count - 1);
   endtask

   // One register write; the caller lowers csr_valid after the last one.
   task automatic csr_handshake(input wbps_pkg::csr_index_type idx,
                                input logic [wbps_pkg::WORD_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == wbps_pkg::CSR_PATTERN_LENGTH) begin
         sig_length = value[wbps_pkg::CFG_LEN_BITS-1:0];
      end else begin
         sig_words[idx - wbps_pkg::CSR_PATTERN_WORD0] = value;
      end
   endtask

   task automatic write_settings(input wbps_pkg::pattern_type words,
                                 input logic [wbps_pkg::WORD_WIDTH-1:0] length_wdata);
      for (int i = 0; i < wbps_pkg::PATTERN_WORDS; i++) begin
         csr_handshake(wbps_pkg::csr_index_type'(wbps_pkg::CSR_PATTERN_WORD0 + i), words[i]);
      end
      csr_handshake(wbps_pkg::CSR_PATTERN_LENGTH, length_wdata);
      csr_valid <= 1'b0;
   endtask

   // Waits until every request is taken and every report is back, then lets the pipe empty.
   task automatic wait_for_drain();
      while (requests_in_flight != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver: holds a stalled request, otherwise sends the next byte or idles.
   always @(posedge clock) begin
      byte_request_type next_item;
      logic             accepted;
      accepted = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (accepted) begin
            scan_byte(req_data_byte, req_region_end);
            requests_in_flight--;
         end
         if (req_valid && !accepted) begin
            // Payload stays put while stalled.
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0 && !quiet_run &&
                      $urandom_range(99) < gap_percent) begin
            gap_left = $urandom_range(12, 0);
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_item = pending_bytes.pop_front();
            req_valid      <= 1'b1;
            req_data_byte  <= next_item.data_byte;
            req_region_end <= next_item.region_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Report monitor and result-side stall generator.
   always @(posedge clock) begin
      region_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report found=%0b offset=%0d another=%0b", $time,
                        rsp_found, rsp_match_offset, rsp_another_match);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
                  failures++;
               end
               if (rsp_match_offset !== want.match_offset) begin
                  $display("%0t: match_offset expected %0d actual %0d", $time,
                           want.match_offset, rsp_match_offset);
                  failures++;
               end
               if (rsp_another_match !== want.another_match) begin
                  $display("%0t: another_match expected %0b actual %0b", $time,
                           want.another_match, rsp_another_match);
                  failures++;
               end
            end
         end
         if (!quiet_run && stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_run && $urandom_range(99) < stall_percent) begin
            stall_left = $urandom_range(12, 0);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("wildcard_byte_pattern_scanner verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed regions first, then random phases with fresh signatures.
   initial begin
      wbps_pkg::pattern_type           words;
      logic [wbps_pkg::WORD_WIDTH-1:0] length_wdata;
      int                              density;
      int                              phase;
      int unsigned                     pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset signature is a single 0x00 byte: match late, two matches, no match.
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      wait_for_drain();

      // Signature 00 * FF; upper words all ones and all zeros.
      words = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5A5A_5A5A_5AFF_2A00};
      write_settings(words, 64'd3);
      push_byte(8'h00, 1'b0);
      push_byte(8'h77, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h2A, 1'b0);
      push_byte(8'hFF, 1'b1);
      // A region shorter than the signature.
      push_byte(8'h00, 1'b0);
      push_byte(8'h5A, 1'b1);
      wait_for_drain();

      // Length register of zero acts as one.
      write_settings(words, 64'hFFFF_FFFF_FFFF_FFC0);
      push_byte(8'hAB, 1'b0);
      push_byte(8'h00, 1'b1);
      // Length changes from one to three in the middle of a region.
      push_byte(8'h00, 1'b0);
      push_byte(8'h11, 1'b0);
      wait_for_drain();
      write_settings(words, 64'd3);
      push_byte(8'h00, 1'b0);
      push_byte(8'h99, 1'b0);
      push_byte(8'hFF, 1'b1);
      wait_for_drain();

      // Random phases; the last ones run without any idling.
      phase = 0;
      while (items_queued < 1000 || regions_queued < 60) begin
         quiet_run     = items_queued >= 850;
         gap_percent   = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
         stall_percent = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
         density = (phase == 0) ? 100 : $urandom_range(3) * 15;
         for (int i = 0; i < wbps_pkg::MAX_PATTERN; i++) begin
            words[i / 8][(i % 8) * 8 +: 8] =
               ($urandom_range(99) < density) ? wbps_pkg::WILDCARD_BYTE : 8'($urandom);
         end
         length_wdata = {$urandom, $urandom};
         pick = $urandom_range(9);
         if (phase == 0 || pick == 1) begin
            length_wdata[wbps_pkg::CFG_LEN_BITS-1:0] =
               wbps_pkg::CFG_LEN_BITS'(wbps_pkg::MAX_PATTERN);
         end else if (phase == 1) begin
            length_wdata[wbps_pkg::CFG_LEN_BITS-1:0] = wbps_pkg::CFG_LEN_BITS'(1);
         end else if (pick == 0) begin
            length_wdata[wbps_pkg::CFG_LEN_BITS-1:0] = '0;
         end else if (pick == 2) begin
            length_wdata[wbps_pkg::CFG_LEN_BITS-1:0] =
               wbps_pkg::CFG_LEN_BITS'($urandom_range(63, wbps_pkg::MAX_PATTERN + 1));
         end else begin
            length_wdata[wbps_pkg::CFG_LEN_BITS-1:0] =
               wbps_pkg::CFG_LEN_BITS'($urandom_range(6, 1));
         end
         write_settings(words, length_wdata);
         repeat ($urandom_range(12, 6)) begin
            queue_region($urandom_range(3 * span_of(sig_length) + 8, 1));
         end
         wait_for_drain();
         phase++;
      end

      if (failures == 0) begin
         $display("wildcard_byte_pattern_scanner verification clean");
      end else begin
         $display("wildcard_byte_pattern_scanner verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/wbps_pkg.sv
rtl/wbps_match.sv
rtl/wildcard_byte_pattern_scanner.sv
tb/tb_wildcard_byte_pattern_scanner.sv
